### rtl/ghp_pkg.sv
package ghp_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int GEN_BITS_DEF = 8;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int HANDLE_W = 24;
	localparam int HIDX_W   = 16;
	localparam int HGEN_W   = 8;
	localparam int SLOT_W   = 10;

	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HANDLE_W-1:0] handle_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle_out;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   live_count;
		logic                move_valid;
		logic [SLOT_W-1:0]   move_from;
		logic [SLOT_W-1:0]   move_to;
	} rsp_t;

	// one sequencer command per bit
	typedef struct packed {
		logic accept;
		logic look;
		logic val;
		logic move;
		logic fin;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            live;
	} sts_t;

endpackage

### rtl/ghp_ctrl.sv
module ghp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  ghp_pkg::sts_t sts,
	output ghp_pkg::cmd_t cmd
);
	import ghp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_VAL  = 3'd2;
	localparam logic [2:0] S_MOVE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				if (sts.op inside {OP_DESTROY, OP_CHECK}) begin
					state_d = S_VAL;
				end else begin
					cmd.fin = 1'b1;
					state_d = S_DONE;
				end
			end
			S_VAL: begin
				cmd.val = 1'b1;
				if (sts.op == OP_DESTROY && sts.live) begin
					state_d = S_MOVE;
				end else begin
					cmd.fin = 1'b1;
					state_d = S_DONE;
				end
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				cmd.fin  = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// output register frees up as the old item leaves
				if (!out_valid_q || !rsp_stall) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

### rtl/ghp_dp.sv
module ghp_dp #(
	parameter int CAPACITY = ghp_pkg::CAPACITY_DEF,
	parameter int GEN_BITS = ghp_pkg::GEN_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ghp_pkg::req_t req,
	input  ghp_pkg::cmd_t cmd,
	output ghp_pkg::sts_t sts,
	output ghp_pkg::rsp_t rsp
);
	import ghp_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int DW = IW + 1;
	localparam logic [IW-1:0]     LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [DW-1:0]     CAP_D    = DW'(CAPACITY);
	localparam logic [HIDX_W:0]   CAP_H    = (HIDX_W + 1)'(CAPACITY);

	function automatic logic [HGEN_W-1:0] gen_low(input logic [GEN_BITS-1:0] g);
		logic [GEN_BITS+HGEN_W-1:0] ext;
		ext = {{HGEN_W{1'b0}}, g};
		return ext[HGEN_W-1:0];
	endfunction

	// tables, single port each, registered read
	logic [IW-1:0]       i2s_mem [CAPACITY];
	logic [IW-1:0]       s2i_mem [CAPACITY];
	logic [GEN_BITS-1:0] gen_mem [CAPACITY];

	logic                i2s_we, i2s_re, s2i_we, s2i_re, gen_we, gen_re;
	logic [IW-1:0]       i2s_addr, i2s_wd, i2s_rd_q;
	logic [IW-1:0]       s2i_addr, s2i_wd, s2i_rd_q;
	logic [IW-1:0]       gen_addr;
	logic [GEN_BITS-1:0] gen_wd, gen_rd_q;

	// item registers
	logic [OP_W-1:0]     op_q;
	logic [IW-1:0]       idx_q;
	logic [HGEN_W-1:0]   hgen_q;
	logic                idx_ok_q;
	logic [IW-1:0]       s_q;
	logic [GEN_BITS-1:0] gen_q;
	rsp_t                res_q;
	rsp_t                out_q;

	// pool registers
	logic [IW-1:0]       free_head_q;
	logic [DW-1:0]       dense_q;
	logic [DW-1:0]       hw_q;

	logic [HIDX_W-1:0]   hid;
	logic [IW-1:0]       acc_idx;
	logic                unwr;
	logic [IW-1:0]       chain;
	logic [IW-1:0]       i2s_v;
	logic [GEN_BITS-1:0] gen_v;
	logic                full;
	logic [DW-1:0]       back_d;
	logic [IW-1:0]       back;
	logic                live;
	logic                mv;
	logic                is_create, is_destroy, is_check;
	logic                do_create, do_free;
	rsp_t                res_d;

	assign hid     = req.handle_id[HIDX_W-1:0];
	assign acc_idx = (req.operation == OP_CREATE) ? free_head_q : hid[IW-1:0];

	// indexes at or above the high-water mark were never written: reset contents
	assign unwr  = ({1'b0, idx_q} >= hw_q);
	assign chain = (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
	assign i2s_v = unwr ? chain : i2s_rd_q;
	assign gen_v = unwr ? '0 : gen_rd_q;

	assign full   = (free_head_q == '0) || (dense_q == CAP_D);
	assign back_d = dense_q - DW'(1);
	assign back   = back_d[IW-1:0];
	assign live   = idx_ok_q && (s_q != '0) && ({1'b0, s_q} < dense_q) &&
		(s2i_rd_q == idx_q) && (hgen_q == gen_low(gen_q));
	assign mv     = ({1'b0, s_q} != back_d);

	assign is_create  = (op_q == OP_CREATE);
	assign is_destroy = (op_q == OP_DESTROY);
	assign is_check   = (op_q == OP_CHECK);
	assign do_create  = cmd.look && is_create && !full;
	assign do_free    = cmd.val && is_destroy && live;

	always_comb begin
		i2s_we   = 1'b0;
		i2s_re   = 1'b0;
		i2s_addr = '0;
		i2s_wd   = '0;
		s2i_we   = 1'b0;
		s2i_re   = 1'b0;
		s2i_addr = '0;
		s2i_wd   = '0;
		gen_we   = 1'b0;
		gen_re   = 1'b0;
		gen_addr = '0;
		gen_wd   = '0;
		if (cmd.accept) begin
			i2s_re   = 1'b1;
			i2s_addr = acc_idx;
			gen_re   = 1'b1;
			gen_addr = acc_idx;
		end
		if (do_create) begin
			i2s_we   = 1'b1;
			i2s_addr = idx_q;
			i2s_wd   = dense_q[IW-1:0];
			s2i_we   = 1'b1;
			s2i_addr = dense_q[IW-1:0];
			s2i_wd   = idx_q;
			// a fresh index gets its generation stored on first use
			gen_we   = 1'b1;
			gen_addr = idx_q;
			gen_wd   = gen_v;
		end
		if (cmd.look && (is_destroy || is_check)) begin
			s2i_re   = 1'b1;
			s2i_addr = i2s_v;
		end
		if (cmd.val) begin
			s2i_re   = 1'b1;
			s2i_addr = back;
		end
		if (do_free) begin
			i2s_we   = 1'b1;
			i2s_addr = idx_q;
			i2s_wd   = free_head_q;
			gen_we   = 1'b1;
			gen_addr = idx_q;
			gen_wd   = gen_q + GEN_BITS'(1);
		end
		if (cmd.move && mv) begin
			// relink the former last entry into the freed slot
			i2s_we   = 1'b1;
			i2s_addr = s2i_rd_q;
			i2s_wd   = s_q;
			s2i_we   = 1'b1;
			s2i_addr = s_q;
			s2i_wd   = s2i_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (i2s_we) begin
			i2s_mem[i2s_addr] <= i2s_wd;
		end else if (i2s_re) begin
			i2s_rd_q <= i2s_mem[i2s_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s2i_we) begin
			s2i_mem[s2i_addr] <= s2i_wd;
		end else if (s2i_re) begin
			s2i_rd_q <= s2i_mem[s2i_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_addr] <= gen_wd;
		end else if (gen_re) begin
			gen_rd_q <= gen_mem[gen_addr];
		end
	end

	always_comb begin
		res_d            = '0;
		res_d.status     = ST_INVALID;
		res_d.live_count = SLOT_W'(back_d);
		if (cmd.look && is_create) begin
			if (full) begin
				res_d.status = ST_FULL;
			end else begin
				res_d.status     = ST_OK;
				res_d.handle_out = {gen_low(gen_v), HIDX_W'(idx_q)};
				res_d.slot       = SLOT_W'(dense_q);
				res_d.live_count = SLOT_W'(dense_q);
			end
		end
		if (cmd.val && live) begin
			res_d.status = ST_OK;
			if (is_check) begin
				res_d.slot = SLOT_W'(s_q);
			end
		end
		if (cmd.move) begin
			res_d.status     = ST_OK;
			res_d.live_count = SLOT_W'(dense_q - DW'(2));
			if (mv) begin
				res_d.move_valid = 1'b1;
				res_d.move_from  = SLOT_W'(back);
				res_d.move_to    = SLOT_W'(s_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= req.operation;
			idx_q    <= acc_idx;
			hgen_q   <= req.handle_id[HIDX_W+HGEN_W-1:HIDX_W];
			idx_ok_q <= (hid != '0) && ({1'b0, hid} < CAP_H);
		end
		if (cmd.look) begin
			s_q   <= i2s_v;
			gen_q <= gen_v;
		end
		if (cmd.fin) begin
			res_q <= res_d;
		end
		if (cmd.load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= IW'(1);
			dense_q     <= DW'(1);
			hw_q        <= DW'(1);
		end else begin
			if (do_create) begin
				free_head_q <= i2s_v;
				dense_q     <= dense_q + DW'(1);
				if (unwr) begin
					hw_q <= {1'b0, idx_q} + DW'(1);
				end
			end
			if (do_free) begin
				free_head_q <= idx_q;
			end
			if (cmd.move) begin
				dense_q <= dense_q - DW'(1);
			end
		end
	end

	assign sts.op   = op_q;
	assign sts.live = live;
	assign rsp      = out_q;

endmodule

### rtl/generational_handle_pool.sv
// from the accepting edge to the result in the output register: create and unknown operation
// go through LOOK and DONE, check and failed destroy through LOOK, VAL and DONE, successful
// destroy through LOOK, VAL, MOVE and DONE; one item in work at a time; the next item is
// accepted the cycle after the result is registered; DONE waits while the output is stalled
// reset: asynchronous, active low; tables are not swept, a high-water mark makes
// never-used entries read as their reset contents, so items are taken right after reset
module generational_handle_pool #(
	parameter int CAPACITY = ghp_pkg::CAPACITY_DEF,
	parameter int GEN_BITS = ghp_pkg::GEN_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ghp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ghp_pkg::rsp_t rsp
);
	import ghp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ghp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ghp_dp #(
		.CAPACITY (CAPACITY),
		.GEN_BITS (GEN_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

### rtl/ghp_check.sv
module ghp_check (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input ghp_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ghp_pkg::rsp_t rsp
);
	import ghp_pkg::*;

	// a result held back keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item accepted while another is in work");

	// failures carry no handle, slot or move
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
		(rsp.handle_out == '0) && (rsp.slot == '0) && !rsp.move_valid)
		else $error("failed item carries payload");

	// a move always comes from the old last slot
	a_move_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.move_valid |->
		(rsp.status == ST_OK) && (rsp.move_from == rsp.live_count + 10'd1))
		else $error("move not from last dense slot");

	// index zero is never handed out
	a_no_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_OK) && (rsp.handle_out != '0) |->
		(rsp.handle_out[HIDX_W-1:0] != '0))
		else $error("handle with index zero");

endmodule

bind generational_handle_pool ghp_check u_check (.*);

### tb/sv/tb.sv
module tb;

	import ghp_pkg::*;

	localparam int CAP         = ghp_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	generational_handle_pool u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// shadow of the pool tables
	logic [SLOT_W-1:0] idx_slot [CAP];
	logic [SLOT_W-1:0] slot_idx [CAP];
	logic [HGEN_W-1:0] gen_tab  [CAP];
	int unsigned       free_head;
	int unsigned       dense_cnt;

	req_t         queued_ops [$];
	rsp_t         pool_answers [$];
	logic [23:0]  live_h [$];
	logic [23:0]  stale_h [$];

	int   errors     = 0;
	int   cycles     = 0;
	int   req_gap    = 0;
	int   req_calm   = 0;
	logic req_fire   = 1'b0;
	int   stall_left = 0;
	int   stall_calm = 0;
	rsp_t want;

	function automatic void pool_reset();
		for (int i = 0; i < CAP; i++) begin
			idx_slot[i] = (i + 1 < CAP) ? SLOT_W'(i + 1) : '0;
			slot_idx[i] = '0;
			gen_tab[i]  = '0;
		end
		free_head = 1;
		dense_cnt = 1;
	endfunction

	function automatic logic pool_lookup(input logic [HANDLE_W-1:0] h,
			output int unsigned idx, output int unsigned s);
		idx = 32'(h[HIDX_W-1:0]);
		s   = 0;
		if (h == '0 || idx == 0 || idx >= CAP)
			return 1'b0;
		s = 32'(idx_slot[idx]);
		if (s == 0 || s >= dense_cnt)
			return 1'b0;
		if (slot_idx[s] != idx)
			return 1'b0;
		if (h[HANDLE_W-1:HIDX_W] != gen_tab[idx])
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic rsp_t apply_op(input req_t r);
		rsp_t        o;
		int unsigned idx;
		int unsigned s;
		int unsigned back;
		int unsigned bidx;
		o = '0;
		o.status = ST_INVALID;
		case (r.operation)
			OP_CREATE: begin
				idx = free_head;
				if (idx == 0 || idx >= CAP || dense_cnt >= CAP) begin
					o.status = ST_FULL;
				end else begin
					free_head = 32'(idx_slot[idx]);
					s = dense_cnt;
					dense_cnt++;
					idx_slot[idx] = SLOT_W'(s);
					slot_idx[s]   = SLOT_W'(idx);
					o.status      = ST_OK;
					o.slot        = SLOT_W'(s);
					o.handle_out  = {gen_tab[idx], idx[HIDX_W-1:0]};
				end
			end
			OP_DESTROY: begin
				if (pool_lookup(r.handle_id, idx, s)) begin
					back = dense_cnt - 1;
					gen_tab[idx]  = gen_tab[idx] + HGEN_W'(1);
					idx_slot[idx] = SLOT_W'(free_head);
					free_head     = idx;
					if (s == back) begin
						slot_idx[s] = '0;
					end else begin
						// last dense entry fills the hole
						bidx = 32'(slot_idx[back]);
						idx_slot[bidx] = SLOT_W'(s);
						slot_idx[s]    = SLOT_W'(bidx);
						slot_idx[back] = '0;
						o.move_valid   = 1'b1;
						o.move_from    = SLOT_W'(back);
						o.move_to      = SLOT_W'(s);
					end
					dense_cnt--;
					o.status = ST_OK;
				end
			end
			OP_CHECK: begin
				if (pool_lookup(r.handle_id, idx, s)) begin
					o.status = ST_OK;
					o.slot   = SLOT_W'(s);
				end
			end
			default: ;
		endcase
		o.live_count = SLOT_W'(dense_cnt - 1);
		return o;
	endfunction

	task automatic add_item(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
		req_t r;
		rsp_t e;
		int   i;
		logic found;
		r.operation = op;
		r.handle_id = h;
		e = apply_op(r);
		queued_ops.push_back(r);
		pool_answers.push_back(e);
		if (e.status == ST_OK && op == OP_CREATE)
			live_h.push_back(e.handle_out);
		if (e.status == ST_OK && op == OP_DESTROY) begin
			found = 1'b0;
			for (i = 0; i < live_h.size() && !found; i++) begin
				if (live_h[i] == h) begin
					live_h.delete(i);
					found = 1'b1;
				end
			end
			stale_h.push_back(h);
			if (stale_h.size() > 64)
				void'(stale_h.pop_front());
		end
	endtask

	function automatic logic [HANDLE_W-1:0] noise_handle();
		logic [HANDLE_W-1:0] h;
		h = HANDLE_W'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: h[HIDX_W-1:0] = HIDX_W'($urandom_range(0, CAP - 1));
			2: begin
				if (live_h.size() > 0)
					h = live_h[$urandom_range(0, live_h.size() - 1)] ^ (24'h1 << $urandom_range(0, 23));
			end
			default: h = {8'h00, 6'h00, h[9:0]};
		endcase
		return h;
	endfunction

	// weights in percent; what is left over goes to the unused opcode
	task automatic gen_one(input int w_create, input int w_destroy, input int w_check);
		int                  roll;
		int                  pick;
		logic [HANDLE_W-1:0] h;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		h    = noise_handle();
		if (pick < 70 && live_h.size() > 0)
			h = live_h[$urandom_range(0, live_h.size() - 1)];
		else if (pick < 85 && stale_h.size() > 0)
			h = stale_h[$urandom_range(0, stale_h.size() - 1)];
		if (roll < w_create)
			add_item(OP_CREATE, h);
		else if (roll < w_create + w_destroy)
			add_item(OP_DESTROY, h);
		else if (roll < w_create + w_destroy + w_check)
			add_item(OP_CHECK, h);
		else
			add_item(OP_UNUSED, h);
	endtask

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic cmp_field(input string name, input logic [HANDLE_W-1:0] exp_v,
			input logic [HANDLE_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// request side
	always @(posedge clk)
		req_fire <= req_valid && !req_stall;

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_fire) begin
			// held until taken
		end else if (req_gap > 0) begin
			req_valid <= 1'b0;
			req_gap   <= req_gap - 1;
		end else if (queued_ops.size() > 0) begin
			req       <= queued_ops.pop_front();
			req_valid <= 1'b1;
			if (req_calm > 0) begin
				req_gap  <= 0;
				req_calm <= req_calm - 1;
			end else if ($urandom_range(0, 49) == 0) begin
				req_gap  <= 0;
				req_calm <= 40;
			end else begin
				req_gap <= draw_gap();
			end
		end else begin
			req_valid <= 1'b0;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_calm > 0) begin
			rsp_stall  <= 1'b0;
			stall_calm <= stall_calm - 1;
		end else if ($urandom_range(0, 99) < 3) begin
			rsp_stall  <= 1'b0;
			stall_calm <= 200;
		end else if ($urandom_range(0, 99) < 25) begin
			rsp_stall  <= 1'b1;
			stall_left <= draw_gap();
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pool_answers.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, rsp);
				errors++;
			end else begin
				want = pool_answers.pop_front();
				cmp_field("status",     HANDLE_W'(want.status),     HANDLE_W'(rsp.status));
				cmp_field("handle_out", want.handle_out,            rsp.handle_out);
				cmp_field("slot",       HANDLE_W'(want.slot),       HANDLE_W'(rsp.slot));
				cmp_field("live_count", HANDLE_W'(want.live_count), HANDLE_W'(rsp.live_count));
				cmp_field("move_valid", HANDLE_W'(want.move_valid), HANDLE_W'(rsp.move_valid));
				cmp_field("move_from",  HANDLE_W'(want.move_from),  HANDLE_W'(rsp.move_from));
				cmp_field("move_to",    HANDLE_W'(want.move_to),    HANDLE_W'(rsp.move_to));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [HANDLE_W-1:0] keep;
		pool_reset();

		// empty pool, zero handle, unused opcode, never-created index, then creates and checks
		add_item(OP_CHECK,   24'h000000);
		add_item(OP_DESTROY, 24'h000000);
		add_item(OP_UNUSED,  24'h000000);
		add_item(OP_CHECK,   24'h000005);
		repeat (3) add_item(OP_CREATE, 24'h000000);
		add_item(OP_CREATE,  24'hFFFFFF);
		add_item(OP_CHECK,   24'h000001);
		add_item(OP_CHECK,   24'h010001);
		add_item(OP_CHECK,   24'h000401);
		add_item(OP_CHECK,   24'h010000);
		add_item(OP_CHECK,   24'hFFFFFF);
		add_item(OP_DESTROY, 24'hFFFFFF);
		add_item(OP_UNUSED,  24'hFFFFFF);
		// destroy with move, stale check and destroy, destroy of the last slot
		add_item(OP_DESTROY, 24'h000001);
		add_item(OP_CHECK,   24'h000001);
		add_item(OP_DESTROY, 24'h000001);
		add_item(OP_DESTROY, 24'h000004);
		add_item(OP_DESTROY, 24'h000002);
		add_item(OP_CREATE,  24'h000000);
		add_item(OP_CHECK,   24'h010002);
		add_item(OP_DESTROY, 24'h000003);
		add_item(OP_DESTROY, 24'h010002);

		// fill until the pool is full, then push against it
		while (dense_cnt < CAP)
			gen_one(93, 3, 3);
		repeat (10) gen_one(60, 5, 35);

		repeat (40) gen_one(30, 40, 25);

		// churn one index until its generation wraps and the old handle lives again
		add_item(OP_CREATE, noise_handle());
		keep = live_h[$urandom_range(0, live_h.size() - 1)];
		add_item(OP_DESTROY, keep);
		repeat (255) begin
			add_item(OP_CREATE, noise_handle());
			if ($urandom_range(0, 9) == 0)
				gen_one(0, 0, 100);
			add_item(OP_DESTROY, live_h[live_h.size() - 1]);
		end
		add_item(OP_CHECK, keep);
		add_item(OP_CREATE, noise_handle());
		add_item(OP_CHECK, keep);
		add_item(OP_DESTROY, keep);

		repeat (20) gen_one(35, 35, 25);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (queued_ops.size() > 0 || req_valid || pool_answers.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
